// ===== sv/btok_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btok_pkg - shared types and constants of the bencode tokenizer
// Byte classes, parser modes, token kinds, status codes, queue sizes and the
// saturation limits of the integer and length accumulators.
// ----------------------------------------------------------------------------
package btok_pkg;

   // Nesting stack size and the widths that follow from it.
   localparam int NEST_DEPTH = 64;
   localparam int NEST_AW    = $clog2(NEST_DEPTH);
   localparam int LEVEL_W    = $clog2(NEST_DEPTH + 1);

   // Queue depths (powers of two, so the pointers wrap on their own).
   localparam int FQ_DEPTH = 2;
   localparam int FQ_AW    = $clog2(FQ_DEPTH);
   localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);
   localparam int RQ_DEPTH = 4;
   localparam int RQ_AW    = $clog2(RQ_DEPTH);
   localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

   // Characters that carry meaning in the stream.
   localparam logic [7:0] CHAR_D     = 8'h64;
   localparam logic [7:0] CHAR_L     = 8'h6c;
   localparam logic [7:0] CHAR_I     = 8'h69;
   localparam logic [7:0] CHAR_E     = 8'h65;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Saturation limits and the thresholds above which one more digit saturates.
   localparam logic [63:0] MAG_LIMIT   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] LEN_LIMIT   = 64'h0000_0000_ffff_ffff;
   localparam logic [63:0] INT_THR_HI  = MAG_LIMIT / 10;
   localparam logic [63:0] INT_THR_LO  = (MAG_LIMIT - 64'd9) / 10;
   localparam logic [63:0] LEN_THR_HI  = LEN_LIMIT / 10;
   localparam logic [63:0] LEN_THR_LO  = (LEN_LIMIT - 64'd9) / 10;

   // Token kinds.
   localparam logic [2:0] TOK_OPEN_DICT  = 3'd0;
   localparam logic [2:0] TOK_OPEN_LIST  = 3'd1;
   localparam logic [2:0] TOK_CLOSE_LIST = 3'd2;
   localparam logic [2:0] TOK_CLOSE_DICT = 3'd3;
   localparam logic [2:0] TOK_INTEGER    = 3'd4;
   localparam logic [2:0] TOK_STR_START  = 3'd5;
   localparam logic [2:0] TOK_STR_BYTE   = 3'd6;
   localparam logic [2:0] TOK_STATUS     = 3'd7;

   // Final status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNTERM    = 2'd1;
   localparam logic [1:0] ST_UNMATCHED = 2'd2;
   localparam logic [1:0] ST_MALFORMED = 2'd3;

   // Container kinds on the nesting stack.
   localparam logic KIND_DICT = 1'b0;
   localparam logic KIND_LIST = 1'b1;

   typedef enum logic [3:0] {
      CLS_DICT,
      CLS_LIST,
      CLS_INT,
      CLS_END,
      CLS_COLON,
      CLS_MINUS,
      CLS_PLUS,
      CLS_DIGIT,
      CLS_OTHER
   } byte_class_type;

   typedef enum logic [2:0] {
      MODE_EXPECT,
      MODE_INT_START,
      MODE_INT_DIGITS,
      MODE_LEN,
      MODE_BODY,
      MODE_STOPPED,
      MODE_STOP_UNMATCHED,
      MODE_STOP_MALFORMED
   } mode_type;

   // One classified input byte.
   typedef struct packed {
      byte_class_type cls;
      logic [3:0]     digit;
      logic [7:0]     data;
      logic           last;
   } item_type;

   // One result token.
   typedef struct packed {
      logic [2:0]         kind;
      logic signed [63:0] value;
      logic               str_end;
      logic [1:0]         status;
      logic               last;
   } token_type;

   // Up to two tokens handed from the parser to the result queue per cycle.
   typedef struct packed {
      logic [1:0] cnt;
      token_type  slot0;
      token_type  slot1;
   } push_type;

endpackage

// ===== sv/btok_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btok_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module btok_ram #(
   parameter int Width = 1,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/btok_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btok_front - input stage of the bencode tokenizer
// Accepts bytes, classifies each one and holds it in a short queue until the
// parser takes it.
// ----------------------------------------------------------------------------
module btok_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   output logic               item_valid,
   output btok_pkg::item_type item,
   input  logic               item_pop
);

   btok_pkg::item_type             cls_item;
   btok_pkg::item_type             entry_ff [btok_pkg::FQ_DEPTH];
   logic [btok_pkg::FQ_AW-1:0]     head_ff, head_in;
   logic [btok_pkg::FQ_AW-1:0]     tail_ff, tail_in;
   logic [btok_pkg::FQ_CW-1:0]     count_ff, count_in;
   logic                           push;

   // Classify the incoming byte.
   always_comb begin
      cls_item.data  = req_data_byte;
      cls_item.last  = req_last_byte;
      cls_item.digit = 4'(req_data_byte - btok_pkg::CHAR_ZERO);
      unique case (req_data_byte)
         btok_pkg::CHAR_D:     cls_item.cls = btok_pkg::CLS_DICT;
         btok_pkg::CHAR_L:     cls_item.cls = btok_pkg::CLS_LIST;
         btok_pkg::CHAR_I:     cls_item.cls = btok_pkg::CLS_INT;
         btok_pkg::CHAR_E:     cls_item.cls = btok_pkg::CLS_END;
         btok_pkg::CHAR_COLON: cls_item.cls = btok_pkg::CLS_COLON;
         btok_pkg::CHAR_MINUS: cls_item.cls = btok_pkg::CLS_MINUS;
         btok_pkg::CHAR_PLUS:  cls_item.cls = btok_pkg::CLS_PLUS;
         default: begin
            if (req_data_byte >= btok_pkg::CHAR_ZERO && req_data_byte <= btok_pkg::CHAR_NINE)
               cls_item.cls = btok_pkg::CLS_DIGIT;
            else
               cls_item.cls = btok_pkg::CLS_OTHER;
         end
      endcase
   end

   // Queue handshake: a transfer is taken whenever the queue has room.
   assign req_stall  = (count_ff == btok_pkg::FQ_CW'(btok_pkg::FQ_DEPTH));
   assign push       = req_valid & ~req_stall;
   assign item_valid = (count_ff != '0);
   assign item       = entry_ff[head_ff];

   // Pointer and fill count updates.
   always_comb begin
      tail_in  = tail_ff + btok_pkg::FQ_AW'(push);
      head_in  = head_ff + btok_pkg::FQ_AW'(item_pop);
      count_in = count_ff + btok_pkg::FQ_CW'(push) - btok_pkg::FQ_CW'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= cls_item;
      end
   end

   // The parser only takes an item that is present.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("parser took an item from an empty queue");

endmodule

// ===== sv/btok_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btok_back - parser of the bencode tokenizer
// Runs the token state machine, keeps the nesting stack and the number
// accumulators, and hands up to two tokens per byte to the result queue.
// ----------------------------------------------------------------------------
module btok_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  btok_pkg::item_type item,
   output logic               item_pop,
   input  logic               room,
   output btok_pkg::push_type push
);

   btok_pkg::mode_type              mode_ff, mode_in;
   logic [btok_pkg::LEVEL_W-1:0]    level_ff, level_in;
   logic                            top_ff, top_in;
   logic [63:0]                     accum_ff, accum_in;
   logic                            neg_ff, neg_in;
   logic                            done_ff, done_in;
   logic [31:0]                     left_ff, left_in;

   logic                            take;
   logic                            nest_wr_en;
   logic [btok_pkg::NEST_AW-1:0]    nest_wr_addr;
   logic                            nest_wr_data;
   logic [btok_pkg::NEST_AW-1:0]    nest_rd_addr;
   logic                            nest_rd_data;

   logic [63:0]                     thr;
   logic [63:0]                     lim;
   logic [63:0]                     acc_next;
   logic [63:0]                     int_val;
   logic                            has_tok;
   btok_pkg::token_type             tok;
   btok_pkg::token_type             stat_tok;
   logic [1:0]                      fin;

   // Take a byte when one is queued and the result queue can hold two tokens.
   assign take     = item_valid & room;
   assign item_pop = take;

   // Nesting stack: the top entry lives in top_ff; the RAM read port always
   // holds the entry below the top for the level of the coming cycle.
   assign nest_rd_addr = btok_pkg::NEST_AW'(level_in - btok_pkg::LEVEL_W'(2));

   btok_ram #(
      .Width(1),
      .Depth(btok_pkg::NEST_DEPTH)
   ) u_nest_ram (
      .clock  (clock),
      .wr_en  (nest_wr_en),
      .wr_addr(nest_wr_addr),
      .wr_data(nest_wr_data),
      .rd_addr(nest_rd_addr),
      .rd_data(nest_rd_data)
   );

   // Saturating decimal digit step for integers and lengths.
   always_comb begin
      if (mode_ff == btok_pkg::MODE_LEN) begin
         thr = (item.digit >= 4'd6) ? btok_pkg::LEN_THR_LO : btok_pkg::LEN_THR_HI;
         lim = btok_pkg::LEN_LIMIT;
      end else begin
         thr = (item.digit == 4'd9) ? btok_pkg::INT_THR_LO : btok_pkg::INT_THR_HI;
         lim = btok_pkg::MAG_LIMIT;
      end
      if (accum_ff > thr)
         acc_next = lim;
      else
         acc_next = (accum_ff << 3) + (accum_ff << 1) + 64'(item.digit);
   end

   // Signed integer value with positive saturation.
   always_comb begin
      if (neg_ff)
         int_val = 64'd0 - accum_ff;
      else if (accum_ff[63])
         int_val = btok_pkg::MAG_LIMIT - 64'd1;
      else
         int_val = accum_ff;
   end

   // Next state and tokens.
   always_comb begin
      mode_in      = mode_ff;
      level_in     = level_ff;
      top_in       = top_ff;
      accum_in     = accum_ff;
      neg_in       = neg_ff;
      done_in      = done_ff;
      left_in      = left_ff;
      nest_wr_en   = 1'b0;
      nest_wr_addr = level_ff[btok_pkg::NEST_AW-1:0];
      nest_wr_data = btok_pkg::KIND_DICT;
      has_tok      = 1'b0;
      tok          = '0;
      stat_tok     = '0;
      fin          = btok_pkg::ST_OK;

      if (take) begin
         unique case (mode_ff) inside
            btok_pkg::MODE_EXPECT: begin
               unique case (item.cls) inside
                  btok_pkg::CLS_DICT, btok_pkg::CLS_LIST: begin
                     if (level_ff >= btok_pkg::LEVEL_W'(btok_pkg::NEST_DEPTH)) begin
                        mode_in = btok_pkg::MODE_STOP_MALFORMED;
                     end else begin
                        nest_wr_en   = 1'b1;
                        nest_wr_data = (item.cls == btok_pkg::CLS_LIST) ?
                                       btok_pkg::KIND_LIST : btok_pkg::KIND_DICT;
                        top_in       = nest_wr_data;
                        level_in     = level_ff + btok_pkg::LEVEL_W'(1);
                        has_tok      = 1'b1;
                        tok.kind     = (item.cls == btok_pkg::CLS_LIST) ?
                                       btok_pkg::TOK_OPEN_LIST : btok_pkg::TOK_OPEN_DICT;
                     end
                  end
                  btok_pkg::CLS_INT: begin
                     accum_in = '0;
                     neg_in   = 1'b0;
                     done_in  = 1'b0;
                     mode_in  = btok_pkg::MODE_INT_START;
                  end
                  btok_pkg::CLS_END: begin
                     if (level_ff == '0) begin
                        mode_in = btok_pkg::MODE_STOP_UNMATCHED;
                     end else begin
                        level_in = level_ff - btok_pkg::LEVEL_W'(1);
                        top_in   = nest_rd_data;
                        has_tok  = 1'b1;
                        if (top_ff == btok_pkg::KIND_LIST) begin
                           tok.kind = btok_pkg::TOK_CLOSE_LIST;
                        end else begin
                           tok.kind = btok_pkg::TOK_CLOSE_DICT;
                           // Closing the outermost dictionary ends the parse.
                           if (level_ff == btok_pkg::LEVEL_W'(1))
                              mode_in = btok_pkg::MODE_STOPPED;
                        end
                     end
                  end
                  btok_pkg::CLS_DIGIT: begin
                     accum_in = 64'(item.digit);
                     neg_in   = 1'b0;
                     done_in  = 1'b0;
                     mode_in  = btok_pkg::MODE_LEN;
                  end
                  default: begin
                     mode_in = btok_pkg::MODE_STOPPED;
                  end
               endcase
            end
            btok_pkg::MODE_INT_START, btok_pkg::MODE_INT_DIGITS: begin
               if (item.cls == btok_pkg::CLS_END) begin
                  has_tok   = 1'b1;
                  tok.kind  = btok_pkg::TOK_INTEGER;
                  tok.value = $signed(int_val);
                  accum_in  = '0;
                  neg_in    = 1'b0;
                  done_in   = 1'b0;
                  mode_in   = btok_pkg::MODE_EXPECT;
               end else if (mode_ff == btok_pkg::MODE_INT_START &&
                            (item.cls == btok_pkg::CLS_MINUS ||
                             item.cls == btok_pkg::CLS_PLUS)) begin
                  neg_in  = (item.cls == btok_pkg::CLS_MINUS);
                  mode_in = btok_pkg::MODE_INT_DIGITS;
               end else begin
                  // The first non-digit ends the digits; the rest is skipped.
                  if (!done_ff && item.cls == btok_pkg::CLS_DIGIT)
                     accum_in = acc_next;
                  else
                     done_in = 1'b1;
                  mode_in = btok_pkg::MODE_INT_DIGITS;
               end
            end
            btok_pkg::MODE_LEN: begin
               if (item.cls == btok_pkg::CLS_DIGIT) begin
                  accum_in = acc_next;
               end else if (item.cls == btok_pkg::CLS_COLON) begin
                  left_in     = accum_ff[31:0];
                  has_tok     = 1'b1;
                  tok.kind    = btok_pkg::TOK_STR_START;
                  tok.value   = $signed(accum_ff);
                  tok.str_end = (accum_ff == '0);
                  accum_in    = '0;
                  neg_in      = 1'b0;
                  done_in     = 1'b0;
                  mode_in     = (accum_ff != '0) ? btok_pkg::MODE_BODY : btok_pkg::MODE_EXPECT;
               end else begin
                  mode_in = btok_pkg::MODE_STOP_MALFORMED;
               end
            end
            btok_pkg::MODE_BODY: begin
               left_in     = left_ff - 32'd1;
               has_tok     = 1'b1;
               tok.kind    = btok_pkg::TOK_STR_BYTE;
               tok.value   = $signed(64'(item.data));
               tok.str_end = (left_ff == 32'd1);
               if (left_ff == 32'd1)
                  mode_in = btok_pkg::MODE_EXPECT;
            end
            default: begin
               // Stopped: bytes are dropped until the final byte.
            end
         endcase

         // Final status from the state this byte leaves behind.
         unique case (mode_in) inside
            btok_pkg::MODE_INT_START, btok_pkg::MODE_INT_DIGITS:
               fin = btok_pkg::ST_UNTERM;
            btok_pkg::MODE_LEN, btok_pkg::MODE_STOP_MALFORMED:
               fin = btok_pkg::ST_MALFORMED;
            btok_pkg::MODE_STOP_UNMATCHED:
               fin = btok_pkg::ST_UNMATCHED;
            default:
               fin = (level_in != '0) ? btok_pkg::ST_MALFORMED : btok_pkg::ST_OK;
         endcase
         stat_tok.kind   = btok_pkg::TOK_STATUS;
         stat_tok.status = fin;
         stat_tok.last   = 1'b1;

         // The final byte returns the parser to its reset state.
         if (item.last) begin
            mode_in  = btok_pkg::MODE_EXPECT;
            level_in = '0;
            accum_in = '0;
            neg_in   = 1'b0;
            done_in  = 1'b0;
            left_in  = '0;
         end
      end

      // Pack the tokens of this byte in order.
      push.cnt = 2'(has_tok) + 2'(take & item.last);
      if (has_tok) begin
         push.slot0 = tok;
         push.slot1 = stat_tok;
      end else begin
         push.slot0 = stat_tok;
         push.slot1 = tok;
      end
   end

   // Parser state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= btok_pkg::MODE_EXPECT;
         level_ff <= '0;
         accum_ff <= '0;
         neg_ff   <= 1'b0;
         done_ff  <= 1'b0;
         left_ff  <= '0;
      end else begin
         mode_ff  <= mode_in;
         level_ff <= level_in;
         accum_ff <= accum_in;
         neg_ff   <= neg_in;
         done_ff  <= done_in;
         left_ff  <= left_in;
      end
   end

   // Top of the nesting stack; meaningful only while a container is open.
   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   // The nesting level never passes the stack size.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= btok_pkg::LEVEL_W'(btok_pkg::NEST_DEPTH))
      else $error("nesting level beyond stack size");

   // A final byte leaves the parser in its reset state.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      take && item.last |=> level_ff == '0 && mode_ff == btok_pkg::MODE_EXPECT)
      else $error("parser not cleared after final byte");

   // A string body always has bytes outstanding.
   a_body_left: assert property (@(posedge clock) disable iff (reset)
      mode_ff == btok_pkg::MODE_BODY |-> left_ff != '0)
      else $error("string body with no bytes left");

endmodule

// ===== sv/btok_rspq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btok_rspq - result queue of the bencode tokenizer
// Takes up to two tokens per cycle from the parser and presents them one per
// transfer on the result channel.
// ----------------------------------------------------------------------------
module btok_rspq (
   input  logic               clock,
   input  logic               reset,
   input  btok_pkg::push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_token_kind,
   output logic signed [63:0] rsp_token_value,
   output logic               rsp_string_end,
   output logic [1:0]         rsp_parse_status,
   output logic               rsp_last_result
);

   btok_pkg::token_type          entry_ff [btok_pkg::RQ_DEPTH];
   btok_pkg::token_type          head;
   logic [btok_pkg::RQ_AW-1:0]   rd_ff, rd_in;
   logic [btok_pkg::RQ_AW-1:0]   wr_ff, wr_in;
   logic [btok_pkg::RQ_AW-1:0]   wr_next;
   logic [btok_pkg::RQ_CW-1:0]   count_ff, count_in;
   logic                         pop;

   // Room for the two tokens a byte may cause.
   assign room      = (count_ff <= btok_pkg::RQ_CW'(btok_pkg::RQ_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid & ~rsp_stall;
   assign wr_next   = wr_ff + btok_pkg::RQ_AW'(1);

   // Head entry drives the result ports.
   assign head             = entry_ff[rd_ff];
   assign rsp_token_kind   = head.kind;
   assign rsp_token_value  = head.value;
   assign rsp_string_end   = head.str_end;
   assign rsp_parse_status = head.status;
   assign rsp_last_result  = head.last;

   // Pointer and fill count updates.
   always_comb begin
      wr_in    = wr_ff + btok_pkg::RQ_AW'(push.cnt);
      rd_in    = rd_ff + btok_pkg::RQ_AW'(pop);
      count_in = count_ff + btok_pkg::RQ_CW'(push.cnt) - btok_pkg::RQ_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end

   // Queue storage, two write slots.
   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         entry_ff[wr_ff] <= push.slot0;
      end
      if (push.cnt == 2'd2) begin
         entry_ff[wr_next] <= push.slot1;
      end
   end

   // The parser never writes more tokens than there is room for.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) + int'(push.cnt) <= btok_pkg::RQ_DEPTH)
      else $error("result queue overflow");

   // A single token per cycle leaves the queue, so two in means the count rises.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push.cnt == 2'd2 |=> count_ff >= btok_pkg::RQ_CW'(1))
      else $error("result queue count lost tokens");

endmodule

// ===== sv/bencode_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bencode_tokenizer - streaming bencode token generator
// Turns a bencoded byte stream into flat tokens with a nesting check and a
// final status token at the last byte of each buffer.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  data_byte[7:0], last_byte
//   rsp_      out        rsp_valid/rsp_stall  token_kind[2:0], token_value[63:0],
//                                             string_end, parse_status[1:0],
//                                             last_result
//
// One byte is accepted per cycle while the input queue has room; the parser
// state machine updates its mode, stack and accumulators once per byte, which
// sets that rate. A result passes through the registered input queue and then
// the result queue before it is offered. A final byte that also closes a token
// yields two results and the result port delivers one per cycle while not stalled.
// Reset is synchronous and clears the queues and parser; the nesting stack RAM
// needs no clearing. Each side may stall on its own: the input queue absorbs a
// stalled parser and the result queue absorbs a stalled consumer.
// ----------------------------------------------------------------------------
module bencode_tokenizer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_token_kind,
   output logic signed [63:0] rsp_token_value,
   output logic               rsp_string_end,
   output logic [1:0]         rsp_parse_status,
   output logic               rsp_last_result
);

   btok_pkg::item_type item;
   btok_pkg::push_type push;
   logic               item_valid;
   logic               item_pop;
   logic               room;

   // Byte intake and classification.
   btok_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .item_valid   (item_valid),
      .item         (item),
      .item_pop     (item_pop)
   );

   // Token state machine and nesting stack.
   btok_back u_back (
      .clock     (clock),
      .reset     (reset),
      .item_valid(item_valid),
      .item      (item),
      .item_pop  (item_pop),
      .room      (room),
      .push      (push)
   );

   // Result delivery.
   btok_rspq u_rspq (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .room            (room),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_value (rsp_token_value),
      .rsp_string_end  (rsp_string_end),
      .rsp_parse_status(rsp_parse_status),
      .rsp_last_result (rsp_last_result)
   );

endmodule

// ===== test/tb_bencode_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bencode_tokenizer - self-checking bench for the bencode tokenizer
// A short table of directed bytes, then random buffers of mostly well-formed
// bencode with broken and noisy buffers mixed in. Every accepted byte runs
// through a local token predictor, and each result transfer is checked field
// by field against the oldest expected token. Both channels idle in bursts.
// ----------------------------------------------------------------------------
module tb_bencode_tokenizer;
   import btok_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_BYTES = 1950;
   localparam int CALM_BYTES   = 1700;
   localparam int TAIL_CYCLES  = 30;
   localparam int PRINT_CAP    = 50;
   localparam token_type NO_TOKEN = '0;

   // One byte of stimulus; typed rows carry their expected tokens.
   typedef struct {
      logic [7:0] data;
      logic       fin;
      bit         typed;
      int         count;
      token_type  tok0;
      token_type  tok1;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_data_byte = 8'h00;
   logic               req_last_byte = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_token_kind;
   logic signed [63:0] rsp_token_value;
   logic               rsp_string_end;
   logic [1:0]         rsp_parse_status;
   logic               rsp_last_result;

   bencode_tokenizer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_value  (rsp_token_value),
      .rsp_string_end   (rsp_string_end),
      .rsp_parse_status (rsp_parse_status),
      .rsp_last_result  (rsp_last_result)
   );

   // Clock and a single reset pulse at the start.
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Predictor state of the tokenizer.
   mode_type    p_mode = MODE_EXPECT;
   logic        nest_stack [NEST_DEPTH];
   int unsigned nest_depth = 0;
   logic [63:0] num_mag = '0;
   logic        num_neg = 1'b0;
   logic        num_end = 1'b0;
   logic [31:0] body_left = '0;

   token_type    step_tokens[$];
   token_type    expected_tokens[$];
   stim_row_type inflight_rows[$];
   stim_row_type directed[$];
   stim_row_type acc_row;
   token_type    got_tok;
   token_type    want_tok;
   logic [7:0]   gen_bytes[$];

   int          mismatch_count = 0;
   int          sent_bytes = 0;
   int          cycle_count = 0;
   int          tx_gap_pct = 20;
   int          rx_pct = 10;
   int          rx_left = 0;
   bit          calm = 1'b0;

   function automatic token_type mk_token(logic [2:0] kind, logic [63:0] value, logic send,
                                          logic [1:0] status, logic last);
      token_type t;
      t.kind    = kind;
      t.value   = value;
      t.str_end = send;
      t.status  = status;
      t.last    = last;
      return t;
   endfunction

   function automatic stim_row_type plain_row(logic [7:0] d, logic fin);
      stim_row_type r;
      r.data  = d;
      r.fin   = fin;
      r.typed = 1'b0;
      r.count = 0;
      r.tok0  = NO_TOKEN;
      r.tok1  = NO_TOKEN;
      return r;
   endfunction

   function automatic stim_row_type typed_row(logic [7:0] d, logic fin, int count,
                                              token_type t0, token_type t1);
      stim_row_type r;
      r       = plain_row(d, fin);
      r.typed = 1'b1;
      r.count = count;
      r.tok0  = t0;
      r.tok1  = t1;
      return r;
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= CHAR_ZERO && b <= CHAR_NINE;
   endfunction

   // One more decimal digit, saturating at the given limit.
   function automatic logic [63:0] sat_digit(logic [63:0] acc, logic [7:0] b, logic [63:0] lim);
      logic [63:0] d;
      d = {56'd0, 8'(b - CHAR_ZERO)};
      if (acc > (lim - d) / 64'd10) return lim;
      return acc * 64'd10 + d;
   endfunction

   function automatic void clear_number();
      num_mag = '0;
      num_neg = 1'b0;
      num_end = 1'b0;
   endfunction

   // Appends one predicted token of the current byte.
   function automatic void add_step_token(token_type t);
      step_tokens.insert(step_tokens.size(), t);
   endfunction

   // Advances the predictor by one byte and leaves its tokens in step_tokens.
   task automatic tokenize_byte(input logic [7:0] b, input logic fin);
      logic [63:0] v;
      logic [1:0]  st;
      step_tokens.delete();
      sent_bytes++;
      case (p_mode)
         MODE_EXPECT: begin
            if (b == CHAR_D || b == CHAR_L) begin
               // An open past the stack size is malformed and emits nothing.
               if (nest_depth >= NEST_DEPTH) begin
                  p_mode = MODE_STOP_MALFORMED;
               end else begin
                  nest_stack[nest_depth] = (b == CHAR_L) ? KIND_LIST : KIND_DICT;
                  nest_depth++;
                  add_step_token(mk_token(b == CHAR_L ? TOK_OPEN_LIST : TOK_OPEN_DICT,
                                          '0, 1'b0, ST_OK, 1'b0));
               end
            end else if (b == CHAR_I) begin
               clear_number();
               p_mode = MODE_INT_START;
            end else if (b == CHAR_E) begin
               if (nest_depth == 0) begin
                  p_mode = MODE_STOP_UNMATCHED;
               end else begin
                  nest_depth--;
                  if (nest_stack[nest_depth] == KIND_LIST) begin
                     add_step_token(mk_token(TOK_CLOSE_LIST, '0, 1'b0, ST_OK, 1'b0));
                  end else begin
                     add_step_token(mk_token(TOK_CLOSE_DICT, '0, 1'b0, ST_OK, 1'b0));
                     // Closing the outermost dictionary ends the parse.
                     if (nest_depth == 0) p_mode = MODE_STOPPED;
                  end
               end
            end else if (is_digit(b)) begin
               clear_number();
               num_mag = {56'd0, 8'(b - CHAR_ZERO)};
               p_mode  = MODE_LEN;
            end else begin
               p_mode = MODE_STOPPED;
            end
         end
         MODE_INT_START, MODE_INT_DIGITS: begin
            if (b == CHAR_E) begin
               if (num_neg) v = 64'd0 - num_mag;
               else v = (num_mag > MAG_LIMIT - 64'd1) ? MAG_LIMIT - 64'd1 : num_mag;
               add_step_token(mk_token(TOK_INTEGER, v, 1'b0, ST_OK, 1'b0));
               clear_number();
               p_mode = MODE_EXPECT;
            end else if (p_mode == MODE_INT_START && (b == CHAR_MINUS || b == CHAR_PLUS)) begin
               num_neg = (b == CHAR_MINUS);
               p_mode  = MODE_INT_DIGITS;
            end else begin
               // The first non-digit ends the digits; the rest up to 'e' is ignored.
               if (!num_end && is_digit(b)) num_mag = sat_digit(num_mag, b, MAG_LIMIT);
               else num_end = 1'b1;
               p_mode = MODE_INT_DIGITS;
            end
         end
         MODE_LEN: begin
            if (is_digit(b)) begin
               num_mag = sat_digit(num_mag, b, LEN_LIMIT);
            end else if (b == CHAR_COLON) begin
               body_left = num_mag[31:0];
               add_step_token(mk_token(TOK_STR_START, num_mag, num_mag == 64'd0,
                                       ST_OK, 1'b0));
               clear_number();
               p_mode = (body_left != 0) ? MODE_BODY : MODE_EXPECT;
            end else begin
               p_mode = MODE_STOP_MALFORMED;
            end
         end
         MODE_BODY: begin
            body_left = body_left - 32'd1;
            add_step_token(mk_token(TOK_STR_BYTE, {56'd0, b}, body_left == 0,
                                    ST_OK, 1'b0));
            if (body_left == 0) p_mode = MODE_EXPECT;
         end
         default: begin
         end
      endcase

      // The final byte adds the status token and returns to the reset state.
      if (fin) begin
         case (p_mode)
            MODE_INT_START, MODE_INT_DIGITS: st = ST_UNTERM;
            MODE_LEN, MODE_STOP_MALFORMED:   st = ST_MALFORMED;
            MODE_STOP_UNMATCHED:             st = ST_UNMATCHED;
            default:                         st = (nest_depth != 0) ? ST_MALFORMED : ST_OK;
         endcase
         add_step_token(mk_token(TOK_STATUS, '0, 1'b0, st, 1'b1));
         p_mode     = MODE_EXPECT;
         nest_depth = 0;
         clear_number();
         body_left  = '0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
   endtask

   // Input transfers feed the predictor; result transfers are checked in order.
   always @(posedge clock) begin
      if (!reset && req_valid === 1'b1 && req_stall === 1'b0) begin
         acc_row = inflight_rows.pop_front();
         tokenize_byte(req_data_byte, req_last_byte);
         if (acc_row.typed) begin
            if (acc_row.count > 0)
               expected_tokens.insert(expected_tokens.size(), acc_row.tok0);
            if (acc_row.count > 1)
               expected_tokens.insert(expected_tokens.size(), acc_row.tok1);
         end else begin
            foreach (step_tokens[i])
               expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
         end
      end
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got_tok = mk_token(rsp_token_kind, rsp_token_value, rsp_string_end,
                            rsp_parse_status, rsp_last_result);
         if (expected_tokens.size() == 0) begin
            report_mismatch("unexpected token kind", {61'd0, got_tok.kind}, '0);
         end else begin
            want_tok = expected_tokens.pop_front();
            if (got_tok.kind !== want_tok.kind)
               report_mismatch("token_kind", {61'd0, got_tok.kind}, {61'd0, want_tok.kind});
            if (got_tok.value !== want_tok.value)
               report_mismatch("token_value", got_tok.value, want_tok.value);
            if (got_tok.str_end !== want_tok.str_end)
               report_mismatch("string_end", {63'd0, got_tok.str_end},
                               {63'd0, want_tok.str_end});
            if (got_tok.status !== want_tok.status)
               report_mismatch("parse_status", {62'd0, got_tok.status},
                               {62'd0, want_tok.status});
            if (got_tok.last !== want_tok.last)
               report_mismatch("last_result", {63'd0, got_tok.last}, {63'd0, want_tok.last});
         end
      end
   end

   // Result side stalls in random bursts; the rate drifts now and then.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rx_left > 0) begin
         rx_left--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < rx_pct) begin
         rx_left = $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
      if ($urandom_range(0, 255) == 0)
         rx_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 30);
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("bencode_tokenizer regression: fail");
      $finish;
   end

   // Drives one byte, with an optional idle burst ahead of it.
   task automatic send_row(input stim_row_type r);
      if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      inflight_rows.insert(inflight_rows.size(), r);
      req_valid     <= 1'b1;
      req_data_byte <= r.data;
      req_last_byte <= r.fin;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   // Holds the sender off until every predicted token has been seen.
   task automatic drain_tokens();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
   endtask

   // Appends one byte to the buffer under construction.
   task automatic add_byte(input logic [7:0] b);
      gen_bytes.insert(gen_bytes.size(), b);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // An integer token: optional sign, digits of many sizes, sometimes junk.
   task automatic gen_int();
      int    r;
      logic [7:0] junk;
      add_byte(CHAR_I);
      r = $urandom_range(0, 9);
      if (r < 3) add_byte(CHAR_MINUS);
      else if (r == 3) add_byte(CHAR_PLUS);
      r = $urandom_range(0, 99);
      if (r < 8) begin
         // Empty body.
      end else if (r < 20) begin
         case ($urandom_range(0, 3))
            0:       push_text("9223372036854775807");
            1:       push_text("9223372036854775808");
            2:       push_text("9223372036854775809");
            default: push_text("184467440737095516150");
         endcase
      end else if (r < 28) begin
         add_byte(8'(CHAR_ZERO + $urandom_range(1, 9)));
         repeat ($urandom_range(14, 21)) add_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end else begin
         push_text($sformatf("%0d", $urandom_range(0, (r < 60) ? 99 : 32'hffff_ffff)));
      end
      if ($urandom_range(0, 9) == 0) begin
         junk = 8'($urandom_range(0, 255));
         if (junk == CHAR_E) junk = CHAR_PLUS;
         add_byte(junk);
         push_text($sformatf("%0d", $urandom_range(0, 999)));
      end
      add_byte(CHAR_E);
   endtask

   // A string token with a short or medium body of arbitrary bytes.
   task automatic gen_str();
      int len;
      len = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 6) : $urandom_range(7, 40);
      if ($urandom_range(0, 9) == 0) add_byte(CHAR_ZERO);
      push_text($sformatf("%0d", len));
      add_byte(CHAR_COLON);
      repeat (len) add_byte(8'($urandom_range(0, 255)));
   endtask

   // A well-formed container tree, built with an explicit stack of open levels.
   task automatic gen_tree(input logic root_kind);
      logic open_kind[$];
      int   child_left[$];
      int   top;
      logic k;
      add_byte(root_kind == KIND_LIST ? CHAR_L : CHAR_D);
      open_kind.insert(open_kind.size(), root_kind);
      child_left.insert(child_left.size(), int'($urandom_range(0, 4)));
      while (open_kind.size() != 0) begin
         top = open_kind.size() - 1;
         if (child_left[top] == 0) begin
            add_byte(CHAR_E);
            open_kind.delete(top);
            child_left.delete(top);
         end else begin
            child_left[top] = child_left[top] - 1;
            if (open_kind[top] == KIND_DICT) gen_str();
            if (open_kind.size() < 4 && $urandom_range(0, 99) < 30) begin
               k = 1'($urandom_range(0, 1));
               add_byte(k == KIND_LIST ? CHAR_L : CHAR_D);
               open_kind.insert(open_kind.size(), k);
               child_left.insert(child_left.size(), int'($urandom_range(0, 3)));
            end else if ($urandom_range(0, 1) == 1) begin
               gen_int();
            end else begin
               gen_str();
            end
         end
      end
   endtask

   // One buffer: mostly well-formed, the rest cut, corrupted, too deep, with huge lengths or noise.
   task automatic build_buffer();
      int pick;
      int k;
      int n;
      gen_bytes.delete();
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         gen_tree(KIND_DICT);
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
      end else if (pick < 70) begin
         // Bare values, outer lists and outer dictionaries; only a closed outer dictionary ends the parse.
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 3))
               0:       gen_int();
               1:       gen_str();
               2:       gen_tree(KIND_LIST);
               default: gen_tree(KIND_DICT);
            endcase
         end
      end else if (pick < 80) begin
         gen_tree(KIND_DICT);
         n = $urandom_range(1, gen_bytes.size());
         gen_bytes = gen_bytes[0:n-1];
      end else if (pick < 87) begin
         gen_tree(KIND_DICT);
         gen_bytes[$urandom_range(0, gen_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick < 92) begin
         // Nesting around the stack size, closed roughly as deep as it was opened.
         k = $urandom_range(60, 68);
         repeat (k) add_byte($urandom_range(0, 1) ? CHAR_L : CHAR_D);
         gen_int();
         repeat ($urandom_range(k - 2, k + 1)) add_byte(CHAR_E);
      end else if (pick < 96) begin
         // Lengths near, at and past the saturation point; the body never completes.
         add_byte(CHAR_D);
         case ($urandom_range(0, 3))
            0:       push_text("4294967295");
            1:       push_text("4294967296");
            2:       push_text("99999999999");
            default: push_text("4294967294");
         endcase
         add_byte(CHAR_COLON);
         repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Appends one row to the directed table.
   task automatic add_row(input stim_row_type r);
      directed.insert(directed.size(), r);
   endtask

   // Directed bytes: unmatched close, an empty signed integer, empty and
   // one-byte strings, two results on one byte, a length without a colon,
   // an unterminated integer, an unknown byte inside a container and a cut string.
   task automatic load_directed();
      add_row(typed_row(CHAR_E, 1'b0, 0, NO_TOKEN, NO_TOKEN));
      add_row(typed_row(8'hff, 1'b1, 1,
                        mk_token(TOK_STATUS, '0, 1'b0, ST_UNMATCHED, 1'b1), NO_TOKEN));
      add_row(typed_row(CHAR_D, 1'b0, 1,
                        mk_token(TOK_OPEN_DICT, '0, 1'b0, ST_OK, 1'b0), NO_TOKEN));
      add_row(typed_row(CHAR_L, 1'b0, 1,
                        mk_token(TOK_OPEN_LIST, '0, 1'b0, ST_OK, 1'b0), NO_TOKEN));
      add_row(plain_row(CHAR_I, 1'b0));
      add_row(plain_row(CHAR_MINUS, 1'b0));
      add_row(typed_row(CHAR_E, 1'b0, 1,
                        mk_token(TOK_INTEGER, '0, 1'b0, ST_OK, 1'b0), NO_TOKEN));
      add_row(plain_row(CHAR_ZERO, 1'b0));
      add_row(typed_row(CHAR_COLON, 1'b0, 1,
                        mk_token(TOK_STR_START, '0, 1'b1, ST_OK, 1'b0), NO_TOKEN));
      add_row(plain_row(8'h31, 1'b0));
      add_row(plain_row(CHAR_COLON, 1'b0));
      add_row(typed_row(8'h00, 1'b0, 1,
                        mk_token(TOK_STR_BYTE, '0, 1'b1, ST_OK, 1'b0), NO_TOKEN));
      add_row(typed_row(CHAR_E, 1'b0, 1,
                        mk_token(TOK_CLOSE_LIST, '0, 1'b0, ST_OK, 1'b0), NO_TOKEN));
      add_row(typed_row(CHAR_E, 1'b1, 2,
                        mk_token(TOK_CLOSE_DICT, '0, 1'b0, ST_OK, 1'b0),
                        mk_token(TOK_STATUS, '0, 1'b0, ST_OK, 1'b1)));
      add_row(plain_row(8'h33, 1'b0));
      add_row(typed_row(8'h78, 1'b1, 1,
                        mk_token(TOK_STATUS, '0, 1'b0, ST_MALFORMED, 1'b1), NO_TOKEN));
      add_row(plain_row(CHAR_I, 1'b0));
      add_row(plain_row(8'h31, 1'b0));
      add_row(typed_row(8'h32, 1'b1, 1,
                        mk_token(TOK_STATUS, '0, 1'b0, ST_UNTERM, 1'b1), NO_TOKEN));
      add_row(typed_row(CHAR_L, 1'b0, 1,
                        mk_token(TOK_OPEN_LIST, '0, 1'b0, ST_OK, 1'b0), NO_TOKEN));
      add_row(plain_row(8'h80, 1'b0));
      add_row(typed_row(CHAR_D, 1'b1, 1,
                        mk_token(TOK_STATUS, '0, 1'b0, ST_MALFORMED, 1'b1), NO_TOKEN));
      add_row(plain_row(8'h32, 1'b0));
      add_row(plain_row(CHAR_COLON, 1'b0));
      add_row(plain_row(8'h61, 1'b1));
   endtask

   // Main sequence: directed table, random buffers, then drain and verdict.
   initial begin
      int base;
      int buffers;
      @(posedge clock);
      while (reset) @(posedge clock);
      @(posedge clock);

      load_directed();
      foreach (directed[i]) send_row(directed[i]);
      drain_tokens();

      base    = sent_bytes;
      buffers = 0;
      while (sent_bytes < base + RANDOM_BYTES) begin
         calm = (sent_bytes >= base + CALM_BYTES);
         if (calm || $urandom_range(0, 3) == 0) tx_gap_pct = 0;
         else tx_gap_pct = $urandom_range(5, 35);
         build_buffer();
         for (int i = 0; i < gen_bytes.size(); i++)
            send_row(plain_row(gen_bytes[i], i == gen_bytes.size() - 1));
         buffers++;
         if (buffers == 12) drain_tokens();
      end

      drain_tokens();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_tokens.size() == 0) begin
         $display("bencode_tokenizer regression: pass");
      end else begin
         $display("bencode_tokenizer regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/btok_pkg.sv
sv/btok_ram.sv
sv/btok_front.sv
sv/btok_back.sv
sv/btok_rspq.sv
sv/bencode_tokenizer.sv
test/tb_bencode_tokenizer.sv
